>>> hw/rtl/qbf_pkg.sv
// ----------------------------------------------------------------------------
// qbf_pkg
// Shared types and constants of the quadratic Bezier flattener.
// ----------------------------------------------------------------------------
`default_nettype none

package qbf_pkg;

	localparam int unsigned COORD_W      = 24;
	localparam int unsigned T_W          = 17;   // Q0.16 plus one integer bit for 1.0
	localparam int unsigned STEP_W       = 16;
	localparam int unsigned SEG_W        = 7;
	localparam int unsigned CFG_ADDR_W   = 2;
	localparam int unsigned MAX_SEGMENTS = 64;

	localparam logic [T_W-1:0] T_ONE = T_W'(65536);

	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

	localparam logic [SEG_W-1:0]  SEGMENTS_RESET = SEG_W'(20);
	localparam logic [STEP_W-1:0] T_STEP_RESET   = STEP_W'(3277);

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_SEGMENTS = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_T_STEP   = 2'd1;

	// Input word kinds
	localparam logic CMD_POINT = 1'b0;
	localparam logic CMD_CURVE = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Interpolation steps of one vertex, issued in this order
	typedef enum logic [2:0] {
		OP_D1X = 3'd0,
		OP_D2X = 3'd1,
		OP_VX  = 3'd2,
		OP_D1Y = 3'd3,
		OP_D2Y = 3'd4,
		OP_VY  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic             start;
		coord_t           a;
		coord_t           b;
		logic [T_W-1:0]   t;
	} lerp_req_t;

	typedef struct packed {
		logic   done;
		coord_t y;
	} lerp_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/qbf_lerp.sv
// ----------------------------------------------------------------------------
// qbf_lerp
// Shared interpolation unit: y = sat(a + floor((b - a) * t / 65536)).
// ----------------------------------------------------------------------------
`default_nettype none

module qbf_lerp (
	input  wire                   clk,
	input  wire                   arst_n,
	input  qbf_pkg::lerp_req_t    req,
	output qbf_pkg::lerp_rsp_t    rsp
);
	import qbf_pkg::*;

	logic                      v_s1, v_s2, v_s3;
	logic signed [COORD_W:0]   diff_s1;
	coord_t                    a_s1, a_s2;
	logic [T_W-1:0]            t_s1;
	logic signed [COORD_W+T_W+1:0] prod_s2;
	coord_t                    y_s3;

	logic signed [COORD_W+T_W-15:0] prod_sh;
	logic signed [COORD_W+T_W-14:0] sum;
	coord_t                    y_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// difference, then product, then shift, add and clamp
	always_ff @(posedge clk) begin
		diff_s1 <= (COORD_W+1)'(req.b) - (COORD_W+1)'(req.a);
		a_s1    <= req.a;
		t_s1    <= req.t;
		prod_s2 <= (COORD_W+T_W+2)'(diff_s1) * (COORD_W+T_W+2)'($signed({1'b0, t_s1}));
		a_s2    <= a_s1;
		y_s3    <= y_sat;
	end

	always_comb begin
		prod_sh = (COORD_W+T_W-14)'(prod_s2 >>> 16);
		sum     = (COORD_W+T_W-13)'(a_s2) + (COORD_W+T_W-13)'(prod_sh);
		if (sum > (COORD_W+T_W-13)'(COORD_MAX))
			y_sat = COORD_MAX;
		else if (sum < (COORD_W+T_W-13)'(COORD_MIN))
			y_sat = COORD_MIN;
		else
			y_sat = sum[COORD_W-1:0];
	end

	assign rsp.done = v_s3;
	assign rsp.y    = y_s3;

endmodule

`default_nettype wire

>>> hw/rtl/qbf_ctrl.sv
// ----------------------------------------------------------------------------
// qbf_ctrl
// Sequencer: steps the interpolation unit through each vertex, drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qbf_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [qbf_pkg::SEG_W-1:0]    seg_eff,
	input  wire  [qbf_pkg::STEP_W-1:0]   t_step,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [4*qbf_pkg::COORD_W-1:0] s_tdata,
	input  wire                          s_tuser,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [2*qbf_pkg::COORD_W-1:0] m_tdata,
	output logic                         m_tlast,
	output qbf_pkg::lerp_req_t           lreq,
	input  qbf_pkg::lerp_rsp_t           lrsp
);
	import qbf_pkg::*;

	state_t state_q, state_d;
	op_t    op_q;
	logic [SEG_W-1:0] k_q;
	logic [T_W-1:0]   t_q;
	logic             fin_q;
	logic             out_valid_q;
	coord_t pen_x_q, pen_y_q, cx_q, cy_q, ex_q, ey_q;
	coord_t d1_q, d2_q, vx_q, vy_q, out_x_q, out_y_q;
	logic             out_last_q;

	logic             in_fire, put_fire, has_interior, more;
	logic [T_W:0]     t_sum;
	logic [T_W-1:0]   t_next;

	assign in_fire      = s_tvalid && s_tready;
	assign put_fire     = (state_q == ST_PUT) && (!out_valid_q || m_tready);
	assign has_interior = (s_tuser == CMD_CURVE) && (seg_eff >= SEG_W'(2));
	assign more         = (k_q + SEG_W'(1)) < seg_eff;
	assign t_sum        = (T_W+1)'(t_q) + (T_W+1)'(t_step);
	assign t_next       = (t_sum > (T_W+1)'(T_ONE)) ? T_ONE : t_sum[T_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pen_x_q     <= '0;
			pen_y_q     <= '0;
		end else begin
			state_q <= state_d;
			if (put_fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (put_fire && fin_q) begin
				pen_x_q <= ex_q;
				pen_y_q <= ey_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cx_q  <= s_tdata[COORD_W-1:0];
			cy_q  <= s_tdata[2*COORD_W-1:COORD_W];
			ex_q  <= s_tdata[3*COORD_W-1:2*COORD_W];
			ey_q  <= s_tdata[4*COORD_W-1:3*COORD_W];
			k_q   <= SEG_W'(1);
			t_q   <= T_W'(t_step);
			op_q  <= OP_D1X;
			fin_q <= !has_interior;
		end
		if (state_q == ST_WAIT && lrsp.done) begin
			unique case (op_q)
				OP_D1X, OP_D1Y: d1_q <= lrsp.y;
				OP_D2X, OP_D2Y: d2_q <= lrsp.y;
				OP_VX:          vx_q <= lrsp.y;
				OP_VY:          vy_q <= lrsp.y;
				default:        d1_q <= lrsp.y;
			endcase
			if (op_q != OP_VY)
				op_q <= op_t'(op_q + 3'd1);
		end
		if (put_fire) begin
			out_x_q    <= fin_q ? ex_q : vx_q;
			out_y_q    <= fin_q ? ey_q : vy_q;
			out_last_q <= fin_q;
			if (!fin_q) begin
				k_q   <= k_q + SEG_W'(1);
				t_q   <= t_next;
				op_q  <= OP_D1X;
				fin_q <= !more;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		lreq.start = 1'b0;
		lreq.t     = t_q;
		lreq.a     = pen_x_q;
		lreq.b     = cx_q;
		unique case (op_q)
			OP_D1X: begin lreq.a = pen_x_q; lreq.b = cx_q; end
			OP_D2X: begin lreq.a = cx_q;    lreq.b = ex_q; end
			OP_D1Y: begin lreq.a = pen_y_q; lreq.b = cy_q; end
			OP_D2Y: begin lreq.a = cy_q;    lreq.b = ey_q; end
			OP_VX, OP_VY: begin lreq.a = d1_q; lreq.b = d2_q; end
			default: begin lreq.a = d1_q; lreq.b = d2_q; end
		endcase
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = has_interior ? ST_ISSUE : ST_PUT;
			end
			ST_ISSUE: begin
				lreq.start = 1'b1;
				state_d    = ST_WAIT;
			end
			ST_WAIT: begin
				if (lrsp.done)
					state_d = (op_q == OP_VY) ? ST_PUT : ST_ISSUE;
			end
			ST_PUT: begin
				// after the last interior vertex the anchor goes out directly
				if (put_fire)
					state_d = fin_q ? ST_IDLE : (more ? ST_ISSUE : ST_PUT);
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_y_q, out_x_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/quadratic_bezier_flattener_top.sv
// ----------------------------------------------------------------------------
// quadratic_bezier_flattener_top
// Flattens quadratic Bezier curves into a stream of polyline vertices.
// ----------------------------------------------------------------------------
// A point word (tuser = 0) moves the pen to (end_x, end_y) and emits that
// point with tlast set. A curve word (tuser = 1) runs from the pen point
// through the control point to the anchor: it emits segments-1 interior
// vertices at t = k * t_step (t clamped to 1.0), then the anchor with tlast
// set, and the anchor becomes the new pen point. Coordinates are signed
// Q16.8; t_step is Q0.16. segments above 64 acts as 64; 0 or 1 emits only
// the anchor. Each interior vertex takes six interpolations, issued one at
// a time on one shared three-stage multiply unit, then a hand-off to the
// output register. The input is taken only while the sequencer is idle; a
// finished vertex waits in the output register while the next one is being
// computed.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_bezier_flattener_top (
	input  wire                               clk,
	input  wire                               arst_n,
	// configuration write port
	input  wire                               cfg_we,
	input  wire  [qbf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire  [qbf_pkg::STEP_W-1:0]        cfg_wdata,
	// input stream
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [4*qbf_pkg::COORD_W-1:0]     s_tdata,   // ctrl_x, ctrl_y, end_x, end_y
	input  wire  [0:0]                        s_tuser,   // cmd
	// vertex stream
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [2*qbf_pkg::COORD_W-1:0]     m_tdata,   // vert_x, vert_y
	output logic                              m_tlast
);
	import qbf_pkg::*;

	logic [SEG_W-1:0]  segments_q;
	logic [STEP_W-1:0] t_step_q;
	logic [SEG_W-1:0]  seg_eff;
	lerp_req_t         lreq;
	lerp_rsp_t         lrsp;

	// Register file: indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segments_q <= SEGMENTS_RESET;
			t_step_q   <= T_STEP_RESET;
		end else if (cfg_we) begin
			if (cfg_addr == REG_SEGMENTS)
				segments_q <= cfg_wdata[SEG_W-1:0];
			else if (cfg_addr == REG_T_STEP)
				t_step_q <= cfg_wdata;
		end
	end

	// Clamp the segment count to the supported maximum.
	assign seg_eff = (segments_q > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : segments_q;

	qbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.seg_eff  (seg_eff),
		.t_step   (t_step_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.lreq     (lreq),
		.lrsp     (lrsp)
	);

	qbf_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lreq),
		.rsp    (lrsp)
	);

endmodule

`default_nettype wire
